### design/spr_anim_pkg.sv
// ----------------------------------------------------------------------------
// spr_anim_pkg
// Types and constants shared by the sprite animation sequencer modules.
// ----------------------------------------------------------------------------
package spr_anim_pkg;

  localparam int DELTA_W    = 10;
  localparam int FPS_W      = 8;
  localparam int TOTAL_W    = 9;
  localparam int COL_W      = 8;
  localparam int SROW_W     = 8;
  localparam int ROW_W      = 10;
  localparam int TPR_W      = 9;
  localparam int PROD_W     = DELTA_W + FPS_W;
  localparam int REM_W      = TPR_W + 1;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 9;

  // accumulator units per frame: ms scaled by fps
  localparam int FRAME_PERIOD = 1000;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FPS         = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_TOTAL = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_COL   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_ROW   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_TILES_ROW   = 3'd5;

  // register reset values
  localparam logic [FPS_W-1:0]   RST_FPS         = 8'd12;
  localparam logic [TOTAL_W-1:0] RST_FRAME_TOTAL = 9'd1;
  localparam logic               RST_LOOP        = 1'b1;
  localparam logic [TPR_W-1:0]   RST_TILES_ROW   = 9'd1;

  // request codes
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [DELTA_W-1:0] delta_ms;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] tile_col;
    logic [ROW_W-1:0] tile_row;
    logic             tile_updated;
    logic             sequence_end;
    logic             playing;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic acc;
    logic step;
    logic div_step;
    logic div_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

### design/spr_anim_dp.sv
// ----------------------------------------------------------------------------
// spr_anim_dp
// Datapath: config registers, frame accumulator, frame counter, restoring
// divider for the column wrap and the output register.
// ----------------------------------------------------------------------------
module spr_anim_dp #(
  parameter int FRAME_BITS = 8,
  parameter int ACC_WIDTH  = 24
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [spr_anim_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [spr_anim_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  spr_anim_pkg::in_t                         in_data,
  input  logic                                      out_ready,
  output logic                                      out_valid,
  output spr_anim_pkg::out_t                        out_data,
  input  spr_anim_pkg::cmd_t                        cmd,
  output spr_anim_pkg::stat_t                       stat
);
  import spr_anim_pkg::*;

  localparam int NEXT_W = FRAME_BITS + 1;
  localparam int DIV_W  = ((NEXT_W > COL_W) ? NEXT_W : COL_W) + 1;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int CMP_W  = (NEXT_W > TOTAL_W) ? NEXT_W : TOTAL_W;
  localparam int RS_W   = (DIV_W > ROW_W) ? DIV_W : ROW_W;

  // config
  logic [FPS_W-1:0]   fps;
  logic [TOTAL_W-1:0] frame_total;
  logic               loop_en;
  logic [COL_W-1:0]   start_col;
  logic [SROW_W-1:0]  start_row;
  logic [TPR_W-1:0]   tiles_row;

  // state
  logic [ACC_WIDTH-1:0]  acc;
  logic [FRAME_BITS-1:0] frame;
  logic                  play;
  logic [COL_W-1:0]      held_col;
  logic [ROW_W-1:0]      held_row;
  logic [CNT_W-1:0]      cnt;

  // working registers
  logic               req_r;
  logic [DELTA_W-1:0] delta_r;
  logic [PROD_W-1:0]  prod;
  logic               upd;
  logic               seq_end;
  logic [REM_W-1:0]   rem;
  logic [DIV_W-1:0]   quo;

  logic [ACC_WIDTH:0]   sum;
  logic [ACC_WIDTH-1:0] sat;
  logic                 adv;
  logic [NEXT_W-1:0]    next;
  logic                 wrap;
  logic [TPR_W-1:0]     per_row;
  logic [REM_W-1:0]     rem_sh;
  logic                 fits;
  logic [REM_W-1:0]     rem_nx;
  logic [RS_W-1:0]      row_sum;

  always_comb begin
    sum     = {1'b0, acc} + (ACC_WIDTH + 1)'(prod);
    sat     = sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
    adv     = (req_r == REQ_TICK) && play && (acc >= ACC_WIDTH'(FRAME_PERIOD));
    next    = NEXT_W'(frame) + NEXT_W'(1);
    // next at or past min(frame_total, 2^FRAME_BITS)
    wrap    = (CMP_W'(next) >= CMP_W'(frame_total)) || next[FRAME_BITS];
    per_row = (tiles_row == '0) ? TPR_W'(1) : tiles_row;
    rem_sh  = {rem[REM_W-2:0], quo[DIV_W-1]};
    fits    = rem_sh >= REM_W'(per_row);
    rem_nx  = fits ? (rem_sh - REM_W'(per_row)) : rem_sh;
    row_sum = RS_W'(start_row) + RS_W'(quo);
  end

  assign stat.need_div = adv && !wrap;
  assign stat.div_done = (cnt == '0);
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fps         <= RST_FPS;
      frame_total <= RST_FRAME_TOTAL;
      loop_en     <= RST_LOOP;
      start_col   <= '0;
      start_row   <= '0;
      tiles_row   <= RST_TILES_ROW;
      acc         <= '0;
      frame       <= '0;
      play        <= 1'b0;
      held_col    <= '0;
      held_row    <= '0;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_FPS:         fps         <= cfg_wdata[FPS_W-1:0];
          CFG_FRAME_TOTAL: frame_total <= cfg_wdata[TOTAL_W-1:0];
          CFG_LOOP:        loop_en     <= cfg_wdata[0];
          CFG_START_COL:   start_col   <= cfg_wdata[COL_W-1:0];
          CFG_START_ROW:   start_row   <= cfg_wdata[SROW_W-1:0];
          CFG_TILES_ROW:   tiles_row   <= cfg_wdata[TPR_W-1:0];
          default: ;
        endcase
      end

      if (cmd.acc) begin
        if (req_r == REQ_RESTART) begin
          play     <= 1'b1;
          frame    <= '0;
          acc      <= '0;
          held_col <= start_col;
          held_row <= ROW_W'(start_row);
        end else if (play) begin
          acc <= sat;
        end
      end

      if (cmd.step && adv) begin
        acc <= acc - ACC_WIDTH'(FRAME_PERIOD);
        if (wrap) begin
          if (!loop_en) begin
            play <= 1'b0;
          end
          held_col <= start_col;
          held_row <= ROW_W'(start_row);
          frame    <= '0;
        end else begin
          frame <= next[FRAME_BITS-1:0];
          cnt   <= CNT_W'(DIV_W);
        end
      end

      if (cmd.div_step) begin
        cnt <= cnt - CNT_W'(1);
      end

      if (cmd.div_commit) begin
        held_col <= rem[COL_W-1:0];
        held_row <= row_sum[ROW_W-1:0];
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r   <= in_data.req_type;
      delta_r <= in_data.delta_ms;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(delta_r) * PROD_W'(fps);
    end
    if (cmd.acc) begin
      upd     <= (req_r == REQ_RESTART);
      seq_end <= 1'b0;
    end
    if (cmd.step && adv) begin
      upd     <= 1'b1;
      seq_end <= wrap;
      rem     <= '0;
      quo     <= DIV_W'(start_col) + DIV_W'(next);
    end
    // restoring division, one quotient bit per cycle
    if (cmd.div_step) begin
      rem <= rem_nx;
      quo <= {quo[DIV_W-2:0], fits};
    end
    if (cmd.out_load) begin
      out_data.tile_col     <= held_col;
      out_data.tile_row     <= held_row;
      out_data.tile_updated <= upd;
      out_data.sequence_end <= seq_end;
      out_data.playing      <= play;
    end
  end

endmodule

### design/spr_anim_ctrl.sv
// ----------------------------------------------------------------------------
// spr_anim_ctrl
// Controller: sequences multiply, accumulate, frame step, column wrap
// division and result hand-off for one item at a time.
// ----------------------------------------------------------------------------
module spr_anim_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output spr_anim_pkg::cmd_t   cmd,
  input  spr_anim_pkg::stat_t  stat
);
  import spr_anim_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_STEP = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC:   state_next = S_STEP;
      S_STEP:  state_next = stat.need_div ? S_DIV : S_FIN;
      S_DIV:   if (stat.div_done) state_next = S_FIN;
      S_FIN:   if (!stat.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready       = (state == S_IDLE);
  assign cmd.load_in    = (state == S_IDLE) && in_valid;
  assign cmd.mul        = (state == S_MUL);
  assign cmd.acc        = (state == S_ACC);
  assign cmd.step       = (state == S_STEP);
  assign cmd.div_step   = (state == S_DIV) && !stat.div_done;
  assign cmd.div_commit = (state == S_DIV) && stat.div_done;
  assign cmd.out_load   = (state == S_FIN) && !stat.out_busy;

endmodule

### design/sprite_animation_sequencer_top.sv
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_top
// Sprite sheet frame animation sequencer, one result beat per input beat.
// ----------------------------------------------------------------------------
// Input beats carry a request: a time tick with elapsed milliseconds or a
// restart. Each input beat yields exactly one output beat with the current
// tile column/row, an updated flag, a sequence end flag and the play state.
// Config registers are written through cfg_we/cfg_addr/cfg_wdata; the user
// must write them only while the block is idle, which the block itself does
// not enforce; a write takes effect at the next edge.
// The output beat is loaded after the multiply, accumulate and frame step
// states, and also after the column wrap when a tick advances to a frame
// inside the sequence: the wrap over tiles_per_row runs in a restoring
// divider, one quotient bit per cycle. The next input beat can be taken in
// the cycle after the result is loaded; one item is done before the next.
// The result sits in an output register; a stalled receiver holds it and
// the block still takes the next input, but stops before loading the next
// result until the held one is taken.
// Reset: config registers return to their defaults, playback stops and the
// tile returns to column 0, row 0; no output beat is pending.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_top #(
  parameter int FRAME_BITS = 8,
  parameter int ACC_WIDTH  = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [spr_anim_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [spr_anim_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  spr_anim_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output spr_anim_pkg::out_t                  out_data
);
  import spr_anim_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spr_anim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  spr_anim_dp #(
    .FRAME_BITS (FRAME_BITS),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

### design/spr_anim_chk.sv
// ----------------------------------------------------------------------------
// spr_anim_chk
// Port-level checks for the sprite animation sequencer, bound to the top.
// ----------------------------------------------------------------------------
module spr_anim_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input spr_anim_pkg::out_t  out_data
);

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_end_updates: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_data.sequence_end || out_data.tile_updated)
    else $error("sequence end without tile update");

  // playback only stops at the end of the sequence
  a_stop_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.tile_updated && !out_data.playing |-> out_data.sequence_end)
    else $error("playback stopped away from sequence end");

endmodule

bind sprite_animation_sequencer_top spr_anim_chk u_spr_anim_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### test/sprite_animation_sequencer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_top_tb
// Self-checking bench for the sprite animation sequencer.
// ----------------------------------------------------------------------------
// Drives tick and restart beats through the valid/ready input and rebuilds
// the tile position, frame counter and accumulator in a scoreboard class,
// one expected tile per accepted beat. A directed run covers the register
// and field extremes, then random phases reprogram the registers between
// bursts; both sides stall at random in the first eight phases only.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_top_tb;
  import spr_anim_pkg::*;

  localparam int FRAME_BITS   = 8;
  localparam int ACC_BITS     = 24;
  localparam int FRAME_LIMIT  = 1 << FRAME_BITS;
  localparam longint ACC_MAX  = (longint'(1) << ACC_BITS) - 1;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 165;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 20;
  localparam int QUIET_LIMIT  = 5000;

  class anim_scoreboard;
    logic [FPS_W-1:0]   fps;
    logic [TOTAL_W-1:0] frame_total;
    logic               loop_en;
    logic [COL_W-1:0]   start_col;
    logic [SROW_W-1:0]  start_row;
    logic [TPR_W-1:0]   tiles_row;
    logic [ACC_BITS-1:0]   acc;
    logic [FRAME_BITS-1:0] frame;
    logic               playing;
    logic [COL_W-1:0]   col_q;
    logic [ROW_W-1:0]   row_q;
    out_t               due_tiles[$];
    int                 errors;

    function new();
      fps = RST_FPS;
      frame_total = RST_FRAME_TOTAL;
      loop_en = RST_LOOP;
      start_col = '0;
      start_row = '0;
      tiles_row = RST_TILES_ROW;
      acc = '0;
      frame = '0;
      playing = 1'b0;
      col_q = '0;
      row_q = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_FPS:         fps = val[FPS_W-1:0];
        CFG_FRAME_TOTAL: frame_total = val[TOTAL_W-1:0];
        CFG_LOOP:        loop_en = val[0];
        CFG_START_COL:   start_col = val[COL_W-1:0];
        CFG_START_ROW:   start_row = val[SROW_W-1:0];
        CFG_TILES_ROW:   tiles_row = val[TPR_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the animation by one accepted beat and queue the tile it yields
    function void take_request(in_t req);
      out_t t;
      longint unsigned sum;
      int unsigned nxt, total, per_row, col, row;
      t.tile_updated = 1'b0;
      t.sequence_end = 1'b0;
      if (req.req_type == REQ_RESTART) begin
        playing = 1'b1;
        frame = '0;
        acc = '0;
        col_q = start_col;
        row_q = ROW_W'(start_row);
        t.tile_updated = 1'b1;
      end else if (playing) begin
        sum = longint'(acc) + longint'(req.delta_ms) * longint'(fps);
        if (sum > ACC_MAX) sum = ACC_MAX;
        acc = ACC_BITS'(sum);
        if (acc >= FRAME_PERIOD) begin
          acc = acc - ACC_BITS'(FRAME_PERIOD);
          nxt = frame + 1;
          total = (frame_total > FRAME_LIMIT) ? FRAME_LIMIT : frame_total;
          t.tile_updated = 1'b1;
          if (nxt >= total) begin
            if (!loop_en) playing = 1'b0;
            col_q = start_col;
            row_q = ROW_W'(start_row);
            frame = '0;
            t.sequence_end = 1'b1;
          end else begin
            per_row = (tiles_row == 0) ? 1 : tiles_row;
            col = start_col + nxt;
            row = start_row + col / per_row;
            col = col % per_row;
            frame = FRAME_BITS'(nxt);
            col_q = COL_W'(col);
            row_q = ROW_W'(row);
          end
        end
      end
      t.tile_col = col_q;
      t.tile_row = row_q;
      t.playing = playing;
      due_tiles.push_back(t);
    endfunction

    function void match_tile(out_t got);
      out_t want;
      if (due_tiles.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: tile beat with none due: col %0d row %0d upd %0b end %0b play %0b",
                   $time, got.tile_col, got.tile_row, got.tile_updated,
                   got.sequence_end, got.playing);
        return;
      end
      want = due_tiles.pop_front();
      if (got.tile_col !== want.tile_col || got.tile_row !== want.tile_row ||
          got.tile_updated !== want.tile_updated ||
          got.sequence_end !== want.sequence_end || got.playing !== want.playing) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: tile mismatch: exp col %0d row %0d upd %0b end %0b play %0b,",
                    " got col %0d row %0d upd %0b end %0b play %0b"},
                   $time, want.tile_col, want.tile_row, want.tile_updated,
                   want.sequence_end, want.playing, got.tile_col, got.tile_row,
                   got.tile_updated, got.sequence_end, got.playing);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;

  anim_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  quiet_cycles;
  bit  hold_req;

  sprite_animation_sequencer_top #(
    .FRAME_BITS(FRAME_BITS),
    .ACC_WIDTH (ACC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (!rst && out_valid && out_ready) sb.match_tile(out_data);
  end

  initial begin
    quiet_cycles = 0;
    @(negedge rst);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  function automatic in_t mk_req(logic kind, logic [DELTA_W-1:0] delta);
    in_t r;
    r.req_type = kind;
    r.delta_ms = delta;
    return r;
  endfunction

  task automatic push_request(in_t req);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_request(req);
  endtask

  // stop offering beats and wait for every due tile, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] f, t, l, c, r, w);
    drain();
    write_cfg(CFG_FPS, f);
    write_cfg(CFG_FRAME_TOTAL, t);
    write_cfg(CFG_LOOP, l);
    write_cfg(CFG_START_COL, c);
    write_cfg(CFG_START_ROW, r);
    write_cfg(CFG_TILES_ROW, w);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config(bit heavy);
    logic [CFG_DATA_W-1:0] f, t, l, c, r, w;
    case ($urandom_range(0, 5))
      0: f = 0;
      1: f = 1;
      2: f = 255;
      3: f = CFG_DATA_W'($urandom_range(0, 511));
      default: f = CFG_DATA_W'($urandom_range(1, 240));
    endcase
    case ($urandom_range(0, 6))
      0: t = 0;
      1: t = 1;
      2: t = 256;
      3: t = CFG_DATA_W'($urandom_range(257, 511));
      4: t = CFG_DATA_W'($urandom_range(2, 300));
      default: t = CFG_DATA_W'($urandom_range(1, 12));
    endcase
    l = CFG_DATA_W'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: c = 0;
      1: c = 255;
      default: c = CFG_DATA_W'($urandom_range(0, 511));
    endcase
    case ($urandom_range(0, 3))
      0: r = 0;
      1: r = 255;
      default: r = CFG_DATA_W'($urandom_range(0, 511));
    endcase
    case ($urandom_range(0, 5))
      0: w = 0;
      1: w = 1;
      2: w = 256;
      3: w = CFG_DATA_W'($urandom_range(257, 511));
      default: w = CFG_DATA_W'($urandom_range(1, 16));
    endcase
    // long playing run at full rate so the accumulator saturates
    if (heavy) begin
      f = 255;
      t = CFG_DATA_W'($urandom_range(257, 511));
      l = 1;
    end
    load_config(f, t, l, c, r, w);
  endtask

  initial begin
    int phase;
    int n;
    bit heavy;
    logic [DELTA_W-1:0] d;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 62;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: ticks while stopped, restart, one-frame sequence
    push_request(mk_req(REQ_TICK, 0));
    push_request(mk_req(REQ_TICK, 1023));
    push_request(mk_req(REQ_RESTART, 1023));
    push_request(mk_req(REQ_TICK, 1000));
    push_request(mk_req(REQ_TICK, 83));
    // short sequence with row wrap, then stop at the end
    load_config(240, 5, 0, 254, 255, 3);
    push_request(mk_req(REQ_RESTART, 0));
    push_request(mk_req(REQ_TICK, 5));
    push_request(mk_req(REQ_TICK, 4));
    push_request(mk_req(REQ_TICK, 1023));
    push_request(mk_req(REQ_TICK, 1023));
    push_request(mk_req(REQ_TICK, 0));
    push_request(mk_req(REQ_TICK, 1023));
    // zero frame rate, zero frame total, zero tiles per row
    load_config(0, 0, 1, 255, 0, 0);
    push_request(mk_req(REQ_RESTART, 512));
    push_request(mk_req(REQ_TICK, 1023));
    load_config(255, 0, 1, 255, 0, 0);
    push_request(mk_req(REQ_TICK, 1023));
    push_request(mk_req(REQ_RESTART, 341));
    // oversized register data, frame total past the counter range
    load_config(511, 511, 1, 511, 511, 0);
    push_request(mk_req(REQ_RESTART, 682));
    repeat (5) push_request(mk_req(REQ_TICK, 1023));
    // exact frame period boundary
    load_config(1, 256, 1, 0, 0, 256);
    push_request(mk_req(REQ_RESTART, 0));
    push_request(mk_req(REQ_TICK, 1000));
    push_request(mk_req(REQ_TICK, 999));

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 33;
        recv_idle_pct = 62;
      end else if (phase < 8) begin
        send_idle_pct = 62;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      heavy = (phase == 2 || phase == 10);
      random_config(heavy);
      if (phase == 1 || phase == 9) hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (!sb.playing ? ($urandom_range(0, 1) == 1)
                        : ($urandom_range(0, 99) < (heavy ? 0 : 4))) begin
          push_request(mk_req(REQ_RESTART, DELTA_W'($urandom_range(0, 1023))));
        end else begin
          if (heavy) d = DELTA_W'($urandom_range(900, 1023));
          else begin
            case ($urandom_range(0, 7))
              0: d = 0;
              1: d = 1023;
              2: d = 1000;
              3: d = DELTA_W'($urandom_range(0, 1023));
              default: d = DELTA_W'($urandom_range(0, 60));
            endcase
          end
          push_request(mk_req(REQ_TICK, d));
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.due_tiles.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
